// ===== hw/rtl/b64d_pkg.sv =====
// Shared types, constants and the character lookup for the base64 decoder.
// No dependencies; the top, front, queue and back RTL files import this package.
`default_nettype none

package b64d_pkg;

  // Depth of the queue between the classify front and the emit back
  localparam int QDepth = 4;
  localparam int QAw    = $clog2(QDepth);
  localparam int QCw    = $clog2(QDepth + 1);

  // Pad character, ends decoding like any non-alphabet code
  localparam logic [7:0] CHAR_PAD = 8'h3D;

  // One queued group: up to three results of a single input word
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [1:0] n;        // number of results, 1..3
    logic       bvalid;   // 0 only for a bare end marker
    logic       msg_end;  // final group of the message
    logic       halted;   // decoding stopped in this message
  } b64d_entry_t;

  // Six-bit value of an ASCII code; bit 6 set for a code outside the alphabet
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [6:0] v;
    v = 7'd64;
    if (c inside {[8'h41:8'h5A]}) begin
      v = {1'b0, 6'(c - 8'h41)};
    end else if (c inside {[8'h61:8'h7A]}) begin
      v = {1'b0, 6'(c - 8'h61 + 8'd26)};
    end else if (c inside {[8'h30:8'h39]}) begin
      v = {1'b0, 6'(c - 8'h30 + 8'd52)};
    end else if (c == 8'h2B) begin
      v = 7'd62;
    end else if (c == 8'h2F) begin
      v = 7'd63;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/b64d_if.sv =====
// Valid/ready channel interfaces for the decoder's character input and byte output.
// No dependencies.
`default_nettype none

interface b64d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       msg_last;

  modport source (output valid, output in_char, output msg_last, input ready);
  modport sink   (input valid, input in_char, input msg_last, output ready);
endinterface

interface b64d_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       msg_end;
  logic       halted_early;
  logic       run_last;

  modport source (output valid, output out_byte, output byte_valid, output msg_end,
                  output halted_early, output run_last, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input msg_end,
                  input halted_early, input run_last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/base64_stream_decoder_unit.sv =====
// Streaming base64 decoder (standard alphabet A-Z a-z 0-9 + /), one character per word.
//
// in_chan  (sink):   in_char, msg_last; a word moves when valid and ready are high.
// out_chan (source): out_byte, byte_valid, msg_end, halted_early, run_last.
// Four characters give three bytes, most significant first. The first '=' or
// non-alphabet code halts decoding; the partial group of n characters gives
// n-1 bytes and the rest of the message is dropped. The last word of a message
// always yields a result marked msg_end, a bare marker (byte_valid 0) if no
// byte is left.
// Throughput: one character per cycle and one result per cycle while the receiver is
// ready; the output port limits a burst of groups, the input stalls only when the
// four-entry queue is full. Groups are registered in the queue, then in the back end.
// Reset (rst_n low, synchronous) clears the group state and empties the queue.
// When the receiver stalls, the held result stays stable and the queue fills.
// Depends on b64d_pkg, b64d_if, b64d_front, b64d_queue, b64d_back.
`default_nettype none

module base64_stream_decoder_unit
  import b64d_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  b64d_in_if.sink    in_chan,
  b64d_out_if.source out_chan
);

  logic        push;
  b64d_entry_t push_data;
  logic        q_full;
  logic        pop;
  b64d_entry_t pop_data;
  logic        q_empty;

  b64d_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  b64d_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  b64d_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_data   (pop_data),
    .pop      (pop),
    .out_chan (out_chan)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/b64d_front.sv =====
// Front end: accepts characters, maps them to sextets, packs groups and halts.
// Depends on b64d_pkg and b64d_in_if; pushes one entry per productive word.
`default_nettype none

module b64d_front
  import b64d_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  b64d_in_if.sink    in_chan,
  input  wire logic  q_full,
  output logic       push,
  output b64d_entry_t push_data
);

  logic [17:0] store_r, store_nxt;
  logic [1:0]  fill_r, fill_nxt;
  logic        halt_r, halt_nxt;

  logic [6:0]  v;
  logic        bad;
  logic        acc;
  logic [17:0] st1;
  logic [1:0]  fl1;
  logic        h1;
  logic [1:0]  cnt;
  logic        bv;
  logic [7:0]  b0, b1, b2;

  assign in_chan.ready = !q_full;
  assign acc = in_chan.valid && !q_full;

  // Classify the character and work out the group it completes or flushes
  always_comb begin
    v   = sextet_of(in_chan.in_char);
    bad = v[6] || (in_chan.in_char == CHAR_PAD);
    st1 = store_r;
    fl1 = fill_r;
    h1  = halt_r;
    cnt = 2'd0;
    bv  = 1'b1;
    b0  = 8'd0;
    b1  = 8'd0;
    b2  = 8'd0;
    if (!halt_r) begin
      if (bad) begin
        h1 = 1'b1;
        if (fill_r == 2'd2) begin
          cnt = 2'd1;
          b0  = store_r[11:4];
        end else if (fill_r == 2'd3) begin
          cnt = 2'd2;
          b0  = store_r[17:10];
          b1  = store_r[9:2];
        end
        st1 = '0;
        fl1 = 2'd0;
      end else if (fill_r == 2'd3) begin
        cnt = 2'd3;
        b0  = store_r[17:10];
        b1  = store_r[9:2];
        b2  = {store_r[1:0], v[5:0]};
        st1 = '0;
        fl1 = 2'd0;
      end else begin
        st1 = {store_r[11:0], v[5:0]};
        fl1 = fill_r + 2'd1;
      end
    end
    // Message end flushes what is left, or gives a bare end marker
    if (in_chan.msg_last && (cnt == 2'd0)) begin
      if (fl1 == 2'd2) begin
        cnt = 2'd1;
        b0  = st1[11:4];
      end else if (fl1 == 2'd3) begin
        cnt = 2'd2;
        b0  = st1[17:10];
        b1  = st1[9:2];
      end else begin
        cnt = 2'd1;
        bv  = 1'b0;
      end
    end
  end

  assign push              = acc && (cnt != 2'd0);
  assign push_data.b0      = b0;
  assign push_data.b1      = b1;
  assign push_data.b2      = b2;
  assign push_data.n       = cnt;
  assign push_data.bvalid  = bv;
  assign push_data.msg_end = in_chan.msg_last;
  assign push_data.halted  = h1;

  // State update; message end returns everything to zero
  always_comb begin
    store_nxt = store_r;
    fill_nxt  = fill_r;
    halt_nxt  = halt_r;
    if (acc) begin
      if (in_chan.msg_last) begin
        store_nxt = '0;
        fill_nxt  = 2'd0;
        halt_nxt  = 1'b0;
      end else begin
        store_nxt = st1;
        fill_nxt  = fl1;
        halt_nxt  = h1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      store_r <= '0;
      fill_r  <= 2'd0;
      halt_r  <= 1'b0;
    end else begin
      store_r <= store_nxt;
      fill_r  <= fill_nxt;
      halt_r  <= halt_nxt;
    end
  end

  // A message's last word always produces a group
  a_last_pushes: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_chan.msg_last) |-> push)
    else $error("last word produced no group");

  // After the last word the decoder state is clear
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_chan.msg_last) |=> (fill_r == 2'd0) && !halt_r && (store_r == '0))
    else $error("state not cleared at message end");

  // Once halted, only a final word may produce output
  a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && halt_r && !in_chan.msg_last) |-> !push)
    else $error("output after halt");

endmodule

`default_nettype wire

// ===== hw/rtl/b64d_queue.sv =====
// Short register queue between the classify front and the emit back.
// Depends on b64d_pkg for the entry type and depth.
`default_nettype none

module b64d_queue
  import b64d_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire b64d_entry_t push_data,
  output logic       full,
  input  wire logic  pop,
  output b64d_entry_t pop_data,
  output logic       empty
);

  b64d_entry_t     mem_r [QDepth];
  logic [QAw-1:0]  head_r, head_nxt;
  logic [QAw-1:0]  tail_r, tail_nxt;
  logic [QCw-1:0]  cnt_r, cnt_nxt;

  assign full     = (cnt_r == QCw'(QDepth));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[head_r];

  // Pointer and count update
  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      tail_nxt = tail_r + 1'b1;
    end
    if (pop) begin
      head_nxt = head_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Entry storage, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[tail_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("queue underflow");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCw'(QDepth))
    else $error("queue count out of range");

endmodule

`default_nettype wire

// ===== hw/rtl/b64d_back.sv =====
// Back end: takes queued groups and emits their results one word per cycle while the receiver is ready.
// Depends on b64d_pkg and b64d_out_if.
`default_nettype none

module b64d_back
  import b64d_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  q_empty,
  input  wire b64d_entry_t q_data,
  output logic       pop,
  b64d_out_if.source out_chan
);

  b64d_entry_t cur_r, cur_nxt;
  logic        cur_v_r, cur_v_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic        is_last;
  logic        take;

  assign is_last = (idx_r == (cur_r.n - 2'd1));
  assign take    = cur_v_r && out_chan.ready;
  assign pop     = !q_empty && (!cur_v_r || (take && is_last));

  // Result fields from the held group
  always_comb begin
    case (idx_r)
      2'd0:    out_chan.out_byte = cur_r.b0;
      2'd1:    out_chan.out_byte = cur_r.b1;
      2'd2:    out_chan.out_byte = cur_r.b2;
      default: out_chan.out_byte = 8'd0;
    endcase
  end

  assign out_chan.valid        = cur_v_r;
  assign out_chan.byte_valid   = cur_r.bvalid;
  assign out_chan.msg_end      = cur_r.msg_end && is_last;
  assign out_chan.halted_early = cur_r.halted;
  assign out_chan.run_last     = is_last;

  // Load the next group as the current one drains
  always_comb begin
    cur_nxt   = cur_r;
    cur_v_nxt = cur_v_r;
    idx_nxt   = idx_r;
    if (pop) begin
      cur_nxt   = q_data;
      cur_v_nxt = 1'b1;
      idx_nxt   = 2'd0;
    end else if (take) begin
      if (is_last) begin
        cur_v_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r <= 1'b0;
      idx_r   <= 2'd0;
    end else begin
      cur_v_r <= cur_v_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  a_nonempty_group: assert property (@(posedge clk) disable iff (!rst_n)
    cur_v_r |-> (cur_r.n != 2'd0) && (idx_r < cur_r.n))
    else $error("held group has bad count or index");

  a_bare_marker: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_v_r && !cur_r.bvalid) |-> cur_r.msg_end && (cur_r.n == 2'd1)
                                   && (cur_r.b0 == 8'd0))
    else $error("bare marker without message end");

  a_index_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (take && !is_last) |=> cur_v_r && (idx_r == $past(idx_r) + 2'd1))
    else $error("result index did not advance");

endmodule

`default_nettype wire

// ===== bench/base64_stream_decoder_unit_tb.sv =====
// Self-checking bench for base64_stream_decoder_unit: directed and random character streams.
// A scoreboard class predicts every result word; tasks drive the input, an always block the output ready.
// Depends on b64d_pkg, b64d_if and the decoder RTL.
`default_nettype none

module base64_stream_decoder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import b64d_pkg::CHAR_PAD;

  localparam int CycleLimit  = 200000;
  localparam int DrainCycles = 8;
  localparam int RandomItems = 100;

  // One decoded result word
  typedef struct packed {
    logic [7:0] data;
    logic       has_data;
    logic       msg_end;
    logic       halted;
    logic       run_last;
  } b64_byte_t;

  // Predicts decoded bytes from accepted characters and checks the output stream
  class byte_scoreboard;
    b64_byte_t   expected_bytes[$];
    b64_byte_t   run_bytes[$];
    logic [17:0] sextets = '0;
    logic [1:0]  fill    = '0;
    logic        halted  = 1'b0;
    int          errors  = 0;

    // Six-bit value of a character; bit 6 set when it is not in the alphabet
    function logic [6:0] sextet_value(logic [7:0] c);
      logic [7:0] d;
      d = 8'd64;
      if (c >= 8'h41 && c <= 8'h5A) d = c - 8'h41;
      else if (c >= 8'h61 && c <= 8'h7A) d = c - 8'h61 + 8'd26;
      else if (c >= 8'h30 && c <= 8'h39) d = c - 8'h30 + 8'd52;
      else if (c == 8'h2B) d = 8'd62;
      else if (c == 8'h2F) d = 8'd63;
      return d[6:0];
    endfunction

    function void add_byte(logic [7:0] b, logic has);
      b64_byte_t r;
      r = '0;
      r.data = b;
      r.has_data = has;
      run_bytes.push_back(r);
    endfunction

    // Partial group of n sextets gives n-1 bytes
    function void flush_group();
      if (fill == 2'd2) begin
        add_byte(sextets[11:4], 1'b1);
      end else if (fill == 2'd3) begin
        add_byte(sextets[17:10], 1'b1);
        add_byte(sextets[9:2], 1'b1);
      end
      sextets = '0;
      fill = '0;
    endfunction

    function void note_char(logic [7:0] c, logic last);
      logic [6:0] v;
      run_bytes.delete();
      if (!halted) begin
        v = sextet_value(c);
        if (v[6]) begin
          // pad or foreign code: flush what is held and stop decoding
          halted = 1'b1;
          flush_group();
        end else if (fill == 2'd3) begin
          add_byte(sextets[17:10], 1'b1);
          add_byte(sextets[9:2], 1'b1);
          add_byte({sextets[1:0], v[5:0]}, 1'b1);
          sextets = '0;
          fill = '0;
        end else begin
          sextets = {sextets[11:0], v[5:0]};
          fill = fill + 2'd1;
        end
      end
      if (last) begin
        flush_group();
        // nothing left: bare end marker
        if (run_bytes.size() == 0) add_byte(8'h00, 1'b0);
        run_bytes[run_bytes.size() - 1].msg_end = 1'b1;
      end
      foreach (run_bytes[i]) run_bytes[i].halted = halted;
      if (run_bytes.size() > 0) run_bytes[run_bytes.size() - 1].run_last = 1'b1;
      foreach (run_bytes[i]) expected_bytes.push_back(run_bytes[i]);
      if (last) begin
        sextets = '0;
        fill = '0;
        halted = 1'b0;
      end
    endfunction

    function string fmt_byte(b64_byte_t r);
      return $sformatf("byte=%02h valid=%0b end=%0b halted=%0b run_last=%0b",
                       r.data, r.has_data, r.msg_end, r.halted, r.run_last);
    endfunction

    function void check_byte(b64_byte_t got);
      b64_byte_t want;
      if (expected_bytes.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, got %s", $time, fmt_byte(got));
        return;
      end
      want = expected_bytes.pop_front();
      if (got.data !== want.data || got.has_data !== want.has_data ||
          got.msg_end !== want.msg_end || got.halted !== want.halted ||
          got.run_last !== want.run_last) begin
        errors++;
        $display("%0t: word mismatch, expected %s, got %s", $time,
                 fmt_byte(want), fmt_byte(got));
      end
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction
  endclass

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  b64d_in_if  in_if ();
  b64d_out_if out_if ();

  base64_stream_decoder_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  byte_scoreboard sb = new();

  bit in_idle_on   = 1'b1;
  bit out_stall_on = 1'b1;
  int stall_left   = 0;
  int cycle_count  = 0;
  int random_items = 0;

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Sample both channels at the rising edge; watchdog
  always @(posedge clk) begin
    b64_byte_t got;
    if (rst_n) begin
      if (in_if.valid && in_if.ready) sb.note_char(in_if.in_char, in_if.msg_last);
      if (out_if.valid && out_if.ready) begin
        got.data = out_if.out_byte;
        got.has_data = out_if.byte_valid;
        got.msg_end = out_if.msg_end;
        got.halted = out_if.halted_early;
        got.run_last = out_if.run_last;
        sb.check_byte(got);
      end
    end
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver stalls in random bursts
  always @(negedge clk) begin
    if (!out_stall_on) begin
      out_if.ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_if.ready <= 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 12);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  function automatic logic [7:0] alpha_char(int unsigned idx);
    logic [7:0] c;
    if (idx < 26) c = 8'h41 + 8'(idx);
    else if (idx < 52) c = 8'h61 + 8'(idx - 26);
    else if (idx < 62) c = 8'h30 + 8'(idx - 52);
    else if (idx == 62) c = 8'h2B;
    else c = 8'h2F;
    return c;
  endfunction

  // Present one word, optionally after an idle burst, and wait for acceptance
  task automatic send_char(input logic [7:0] c, input logic last);
    int gap;
    if (in_idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.in_char <= c;
    in_if.msg_last <= last;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  // One random message: mostly well-formed, some broken, some pure noise
  task automatic random_message();
    logic [7:0] msg[$];
    logic [6:0] v;
    int len, kind, pos, pad;
    bit stopped;
    bit last;
    kind = $urandom_range(0, 9);
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 12);
    if (kind <= 5) begin
      // whole groups, optional padding
      len = ((len + 3) / 4) * 4;
      for (int i = 0; i < len; i++) msg.push_back(alpha_char($urandom_range(0, 63)));
      pad = $urandom_range(0, 2);
      if (pad >= 1) msg[len - 1] = CHAR_PAD;
      if (pad == 2) msg[len - 2] = CHAR_PAD;
    end else if (kind <= 7) begin
      // truncated, no padding
      for (int i = 0; i < len; i++) msg.push_back(alpha_char($urandom_range(0, 63)));
    end else if (kind == 8) begin
      // one halting code somewhere, valid text around it
      for (int i = 0; i < len; i++) msg.push_back(alpha_char($urandom_range(0, 63)));
      pos = $urandom_range(0, len - 1);
      case ($urandom_range(0, 2))
        0: msg[pos] = CHAR_PAD;
        1: msg[pos] = 8'($urandom_range(0, 42));
        default: msg[pos] = 8'($urandom_range(128, 255));
      endcase
    end else begin
      for (int i = 0; i < len; i++) msg.push_back(8'($urandom_range(0, 255)));
    end

    stopped = 1'b0;
    foreach (msg[i]) begin
      last = (i == msg.size() - 1);
      // words dropped after a halt do not count
      if (!stopped || last) random_items++;
      v = sb.sextet_value(msg[i]);
      if (v[6]) stopped = 1'b1;
      send_char(msg[i], last);
    end
  endtask

  initial begin
    bit paused;
    in_if.valid = 1'b0;
    in_if.in_char = 8'h00;
    in_if.msg_last = 1'b0;
    out_if.ready = 1'b0;
    paused = 1'b0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: alphabet extremes, padding, lone characters, halts mid-group
    send_text("AZaz09+/");
    send_text("TQ==");
    send_text("Q");
    send_char(CHAR_PAD, 1'b1);
    send_char("a", 1'b0);
    send_char("b", 1'b0);
    send_char("c", 1'b0);
    send_char(8'h00, 1'b1);
    send_char("a", 1'b0);
    send_char("b", 1'b0);
    send_char(8'hFF, 1'b0);
    send_char("x", 1'b0);
    send_char("y", 1'b1);
    send_char("Z", 1'b0);
    send_char(8'h7B, 1'b1);

    // Random messages in phases: idling, a quiet stretch, idling, quiet tail
    while (random_items < RandomItems) begin
      in_idle_on = (random_items < 40) || (random_items >= 55 && random_items < 85);
      out_stall_on = in_idle_on;
      if (!paused && random_items >= 55) begin
        // hold the sender until the decoder has drained
        paused = 1'b1;
        in_if.valid <= 1'b0;
        do @(negedge clk); while (sb.pending() != 0);
      end
      random_message();
    end

    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);

    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
